@@ hdl/lap_interval_logger_average_macros.svh @@
// ----------------------------------------------------------------------------
// Lap interval logger: assertion macros
// Implication and next-cycle implication checks, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LAP_INTERVAL_LOGGER_AVERAGE_MACROS_SVH
`define LAP_INTERVAL_LOGGER_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
`define LIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lia assertion failed");
`define LIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lia assertion failed");
`else
`define LIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/lia_pkg.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger package
// Widths, depths, command type and sequencer states shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lia_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int IV_W      = 32;
    localparam int TS_W      = 64;
    localparam int SUM_W     = IV_W + IDX_W;
    localparam int LEN_W     = 9;
    localparam int ENT_W     = 9;
    localparam int LEN_RESET = 256;
    localparam int DCNT_W    = $clog2(SUM_W + 1);

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic FUNC_LAP   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic            clr;
        logic [TS_W-1:0] ts;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_LAP,
        S_UPD,
        S_DIVGO,
        S_DIVW,
        S_OUT
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/lia_ram.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lia_div.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger: sum divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_div
    import lia_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [CNT_W:0]    rem_next;

    always_comb begin
        trial    = {r_rem, r_quo[SUM_W-1]};
        qbit     = (trial >= {1'b0, r_dvs});
        rem_next = qbit ? (trial - {1'b0, r_dvs}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], qbit};
            r_rem <= rem_next[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hdl/lia_front.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger: front end
// Accept and classify items into a short command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_front
    import lia_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic            i_func,
    input  wire logic [TS_W-1:0] i_timestamp,
    output logic                 o_full,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  wire logic            i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_cnt == QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp].clr <= (i_func == FUNC_CLEAR);
            r_q[r_wp].ts  <= i_timestamp;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lia_back.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger: back end
// Run each command: interval ring, running sum, average and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lap_interval_logger_average_macros.svh"

module lia_back
    import lia_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic      [TS_W-1:0]  o_elapsed,
    output logic                  o_wrapped,
    output logic      [IV_W-1:0]  o_average,
    output logic      [ENT_W-1:0] o_entries_used
);

    t_back_state      r_state;
    t_back_state      n_state;

    logic [LEN_W-1:0] r_len;
    logic             r_started;
    logic [TS_W-1:0]  r_start_time;
    logic [TS_W-1:0]  r_last_elapsed;
    logic [IDX_W-1:0] r_widx;
    logic             r_full;
    logic [SUM_W-1:0] r_sum;

    logic             r_clr;
    logic [TS_W-1:0]  r_ts;
    logic [TS_W-1:0]  r_elapsed;
    logic             r_wrapped;
    logic [IV_W-1:0]  r_iv;
    logic [CNT_W-1:0] r_count;
    logic [IV_W-1:0]  r_avg;

    logic             r_ovalid;
    logic [TS_W-1:0]  r_o_elapsed;
    logic             r_o_wrapped;
    logic [IV_W-1:0]  r_o_average;
    logic [CNT_W-1:0] r_o_count;

    logic [CNT_W-1:0] len_act;
    logic [IDX_W-1:0] idx_eff;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] count_now;
    logic [TS_W-1:0]  diff;
    logic [IV_W-1:0]  ram_rdata;
    logic             ram_we;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic             out_free;

    always_comb begin
        if (r_len == '0) begin
            len_act = CNT_W'(1);
        end else if (int'(r_len) > LOG_DEPTH) begin
            len_act = CNT_W'(LOG_DEPTH);
        end else begin
            len_act = CNT_W'(r_len);
        end
        idx_eff   = (CNT_W'(r_widx) >= len_act) ? '0 : r_widx;
        idx_inc   = CNT_W'(idx_eff) + CNT_W'(1);
        count_now = r_full ? len_act : CNT_W'(r_widx);
        diff      = r_elapsed - r_last_elapsed;
        out_free  = !r_ovalid || i_pop;
    end

    lia_ram #(
        .WIDTH (IV_W),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_eff),
        .i_wdata (r_iv),
        .i_raddr (idx_eff),
        .o_rdata (ram_rdata)
    );

    lia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (count_now),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_CALC;
                end
            end
            S_CALC: begin
                n_state = (r_clr || !r_started) ? S_DIVGO : S_LAP;
            end
            S_LAP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                ram_we  = 1'b1;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                if (count_now == '0) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= LEN_W'(LEN_RESET);
            r_started      <= 1'b0;
            r_start_time   <= '0;
            r_last_elapsed <= '0;
            r_widx         <= '0;
            r_full         <= 1'b0;
            r_sum          <= '0;
        end else begin
            case (r_state)
                S_CALC: begin
                    if (r_clr) begin
                        r_started      <= 1'b0;
                        r_start_time   <= '0;
                        r_last_elapsed <= '0;
                        r_widx         <= '0;
                        r_full         <= 1'b0;
                        r_sum          <= '0;
                    end else if (!r_started) begin
                        r_started      <= 1'b1;
                        r_start_time   <= r_ts;
                        r_last_elapsed <= '0;
                    end
                end
                S_LAP: begin
                    if (r_full) begin
                        r_sum <= r_sum - SUM_W'(ram_rdata);
                    end
                end
                S_UPD: begin
                    r_sum          <= r_sum + SUM_W'(r_iv);
                    r_last_elapsed <= r_elapsed;
                    if (idx_inc >= len_act) begin
                        r_widx <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_widx <= idx_inc[IDX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                r_len          <= i_cfg_data;
                r_started      <= 1'b0;
                r_start_time   <= '0;
                r_last_elapsed <= '0;
                r_widx         <= '0;
                r_full         <= 1'b0;
                r_sum          <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_clr <= i_cmd.clr;
                r_ts  <= i_cmd.ts;
            end
            S_CALC: begin
                r_wrapped <= 1'b0;
                r_elapsed <= (r_clr || !r_started) ? '0 : (r_ts - r_start_time);
            end
            S_LAP: begin
                r_iv <= (diff[TS_W-1:IV_W] != '0) ? '1 : diff[IV_W-1:0];
            end
            S_UPD: begin
                r_wrapped <= (idx_inc >= len_act);
            end
            S_DIVGO: begin
                r_count <= count_now;
                r_avg   <= '0;
            end
            S_DIVW: begin
                if (div_done) begin
                    r_avg <= div_quo[IV_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_elapsed <= r_elapsed;
            r_o_wrapped <= r_wrapped;
            r_o_average <= r_avg;
            r_o_count   <= r_count;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_elapsed      = r_o_elapsed;
    assign o_wrapped      = r_o_wrapped;
    assign o_average      = r_o_average;
    assign o_entries_used = ENT_W'(r_o_count);

    `LIA_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, 1'b1, CNT_W'(r_widx) < len_act)
    `LIA_ASSERT_IMP(a_full_started, i_clk, i_rst_n, r_full, r_started)
    `LIA_ASSERT_IMP(a_div_in_wait, i_clk, i_rst_n, div_done, r_state == S_DIVW)
    `LIA_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == S_OUT && out_free, r_ovalid)

endmodule

`default_nettype wire

@@ hdl/lap_interval_logger_average.sv @@
// ----------------------------------------------------------------------------
// Lap interval logger with running average
// Logs lap intervals in a ring and reports elapsed time and mean interval.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            i_func, i_timestamp
//  result    empty / pop            o_elapsed, o_wrapped, o_average, o_entries_used
//  config    i_cfg_we               i_cfg_data (log_length)
//
//  A lap runs from the queue head through the 40-step restoring divider for
//  the average into the result register. Clear commands and first laps skip
//  the divider. Reset clears all control state; the interval
//  RAM is not cleared. Items queue in a two-entry command queue while the
//  back end works, and a finished result waits in its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_interval_logger_average
    import lia_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             i_func,
    input  wire logic [TS_W-1:0]  i_timestamp,
    output logic                  empty,
    input  wire logic             pop,
    output logic      [TS_W-1:0]  o_elapsed,
    output logic                  o_wrapped,
    output logic      [IV_W-1:0]  o_average,
    output logic      [ENT_W-1:0] o_entries_used,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    lia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_timestamp (i_timestamp),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    lia_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_elapsed      (o_elapsed),
        .o_wrapped      (o_wrapped),
        .o_average      (o_average),
        .o_entries_used (o_entries_used)
    );

endmodule

`default_nettype wire
